/* rtl/nrbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next reaction birth-death step: shared definitions
// Types, codes and default sizes shared by the controller, the datapath and
// the top level.
// ----------------------------------------------------------------------------
package nrbd_pkg;

  localparam int TABLE_DEPTH_DEF    = 1024;
  localparam int STEPS_PER_UNIT_DEF = 100;
  localparam int COUNT_BITS_DEF     = 20;

  localparam logic [47:0] MAX48 = {48{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_STEP,
    OP_NONE
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  localparam logic [1:0] CFG_DEATH_COEF  = 2'd0;
  localparam logic [1:0] CFG_BIRTH_CROWD = 2'd1;
  localparam logic [1:0] CFG_DEATH_CROWD = 2'd2;
  localparam logic [1:0] CFG_END_TIME    = 2'd3;

  typedef enum logic [3:0] {
    MS_N2,
    MS_IP,
    MS_IQ,
    MS_XD,
    MS_DI,
    MS_XB,
    MS_BI,
    MS_T0,
    MS_T1
  } mul_sel_e;

  typedef struct packed {
    logic      cap;
    logic      tbl_wr;
    logic      start;
    logic      idx;
    logic      rd;
    logic      mul_go;
    mul_sel_e  msel;
    logic      div_go;
    logic      div_ch;
    logic      sel;
    logic      adv;
    logic      rates;
    logic      set_st;
    logic [1:0] st;
    logic      out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic end_hit;
    logic ok0;
    logic ok1;
    logic mul_done;
    logic div_done;
  } dp_sts_t;

endpackage

/* rtl/next_reaction_birth_death_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next reaction birth-death step core
// Two-channel logistic birth-death simulation by the modified next reaction
// method, with a time-indexed birth-rate table and external random samples.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | in_valid_i / in_ready_o   | op, table word, count, samples
//  out     | output    | out_valid_o / out_ready_i | time, count, rate, channel, status
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An event step runs up to two radix-2 divisions and nine multiplications on
// one 32x32 partial product unit.
// Reset clears the simulation state and the configuration; the table is not
// cleared. A finished result waits in the output register while the next
// transaction is accepted; the core stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module next_reaction_birth_death_step_core #(
  parameter int TABLE_DEPTH    = nrbd_pkg::TABLE_DEPTH_DEF,
  parameter int STEPS_PER_UNIT = nrbd_pkg::STEPS_PER_UNIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [9:0]  table_index_i,
  input  logic [31:0] table_value_i,
  input  logic [19:0] start_count_i,
  input  logic [31:0] exp_sample_a_i,
  input  logic [31:0] exp_sample_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] time_now_o,
  output logic [19:0] count_now_o,
  output logic [31:0] birth_rate_now_o,
  output logic        fired_channel_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import nrbd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  nrbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nrbd_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .STEPS_PER_UNIT (STEPS_PER_UNIT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .start_count_i    (start_count_i),
    .exp_sample_a_i   (exp_sample_a_i),
    .exp_sample_b_i   (exp_sample_b_i),
    .time_now_o       (time_now_o),
    .count_now_o      (count_now_o),
    .birth_rate_now_o (birth_rate_now_o),
    .fired_channel_o  (fired_channel_o),
    .status_o         (status_o)
  );

endmodule

/* rtl/nrbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next reaction birth-death step: controller
// Sequences table writes, run starts and event steps over the datapath and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module nrbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nrbd_pkg::dp_cmd_t cmd_o,
  input  nrbd_pkg::dp_sts_t sts_i
);
  import nrbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SEL,
    S_MUL_GO,
    S_MUL_WAIT,
    S_ADV,
    S_IDX,
    S_RD,
    S_RATES,
    S_FIN
  } state_e;

  state_e   state_q;
  op_e      op_q;
  logic     rates_q;
  logic     ch_q;
  logic     out_valid_q;
  mul_sel_e msel_q;
  logic     in_acc;
  logic     out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.cap  = in_acc;
    cmd_o.msel = msel_q;
    cmd_o.div_ch = ch_q;
    case (state_q)
      S_DECODE: begin
        case (op_q)
          OP_LOAD:  cmd_o.tbl_wr = 1'b1;
          OP_START: cmd_o.start = 1'b1;
          OP_STEP: begin
            if (sts_i.end_hit) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_END;
            end else if (!sts_i.ok0 && !sts_i.ok1) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_NONE;
            end
          end
          default: ;
        endcase
      end
      S_DIV_GO: cmd_o.div_go = 1'b1;
      S_SEL:    cmd_o.sel = 1'b1;
      S_MUL_GO: cmd_o.mul_go = 1'b1;
      S_ADV:    cmd_o.adv = 1'b1;
      S_IDX:    cmd_o.idx = 1'b1;
      S_RD:     cmd_o.rd = 1'b1;
      S_RATES:  cmd_o.rates = 1'b1;
      S_FIN:    cmd_o.out_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      rates_q     <= 1'b0;
      ch_q        <= 1'b0;
      msel_q      <= MS_N2;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= op_e'(op_i);
            rates_q <= 1'b0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_q)
            OP_START: begin
              rates_q <= 1'b1;
              state_q <= S_IDX;
            end
            OP_STEP: begin
              if (sts_i.end_hit || (!sts_i.ok0 && !sts_i.ok1)) begin
                state_q <= S_IDX;
              end else begin
                ch_q    <= !sts_i.ok0;
                state_q <= S_DIV_GO;
              end
            end
            default: state_q <= S_IDX;
          endcase
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            if (!ch_q && sts_i.ok1) begin
              ch_q    <= 1'b1;
              state_q <= S_DIV_GO;
            end else begin
              state_q <= S_SEL;
            end
          end
        end
        S_SEL: begin
          msel_q  <= MS_T0;
          rates_q <= 1'b1;
          state_q <= S_MUL_GO;
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (sts_i.mul_done) begin
            case (msel_q)
              MS_T1: state_q <= S_ADV;
              MS_BI: state_q <= S_RATES;
              default: begin
                msel_q  <= mul_sel_e'(msel_q + 4'd1);
                state_q <= S_MUL_GO;
              end
            endcase
          end
        end
        S_ADV: state_q <= S_IDX;
        S_IDX: state_q <= S_RD;
        S_RD: begin
          if (rates_q) begin
            msel_q  <= MS_N2;
            state_q <= S_MUL_GO;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_RATES: state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/nrbd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next reaction birth-death step: datapath
// Holds the simulation state, the birth-rate table, a shared 32x32 partial
// product multiplier, a radix-2 divider and the result registers.
// ----------------------------------------------------------------------------
module nrbd_dp #(
  parameter int TABLE_DEPTH    = nrbd_pkg::TABLE_DEPTH_DEF,
  parameter int STEPS_PER_UNIT = nrbd_pkg::STEPS_PER_UNIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nrbd_pkg::dp_cmd_t cmd_i,
  output nrbd_pkg::dp_sts_t sts_o,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [9:0]        table_index_i,
  input  logic [31:0]       table_value_i,
  input  logic [19:0]       start_count_i,
  input  logic [31:0]       exp_sample_a_i,
  input  logic [31:0]       exp_sample_b_i,
  output logic [31:0]       time_now_o,
  output logic [19:0]       count_now_o,
  output logic [31:0]       birth_rate_now_o,
  output logic              fired_channel_o,
  output logic [1:0]        status_o
);
  import nrbd_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(STEPS_PER_UNIT + 1);
  localparam int PW = 32 + SW;
  localparam int IW = PW - 16;
  localparam logic [2:0]  MUL_LAST = 3'd4;
  localparam logic [32:0] CMAX33 = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [60:0] LIM60 = {1'b1, 60'd0};

  function automatic logic [47:0] add48(logic [47:0] x, logic [47:0] y);
    logic [48:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [47:0] clamp48(logic signed [63:0] v);
    logic [47:0] r;
    if (v[63] || (v == 64'sd0)) begin
      r = 48'd0;
    end else if (|v[62:48]) begin
      r = MAX48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [60:0] sat60(logic [127:0] p);
    return (|p[127:61] || (p[60] && |p[59:0])) ? LIM60 : p[60:0];
  endfunction

  // Configuration and simulation state.
  logic [31:0]           death_q, bcrowd_q, dcrowd_q, end_q;
  logic [31:0]           time_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [47:0]           prop_q [2];
  logic [47:0]           it_q [2];
  logic [47:0]           nf_q [2];
  logic                  fired_q;
  logic [1:0]            status_q;

  // Captured input fields.
  logic [9:0]  tidx_q;
  logic [31:0] tval_q;
  logic [19:0] cnt_in_q;
  logic [31:0] smp_a_q, smp_b_q;

  // Table lookup.
  logic [31:0]   tbl_mem [TABLE_DEPTH];
  logic [AW-1:0] idx_q;
  logic [31:0]   rate_q;
  logic [PW-1:0] iprod;
  logic [IW-1:0] iraw;
  logic [AW-1:0] idx_d;
  logic [31:0]   tidx_ext;
  logic          tbl_we;

  // Rate temporaries.
  logic [63:0] n2_q;
  logic [47:0] ip_q, iq_q;
  logic [60:0] xd_q, di_q, xb_q, bi_q;
  logic        neg;
  logic [31:0] mag;
  logic signed [63:0] dth_a, brt_a, dth_f;
  logic [47:0] p0_d, p1_d;

  // Multiplier.
  logic [63:0]  ma_q, mb_q, opa, opb, x64;
  logic [127:0] acc_q, acc_n, pp_sh;
  logic [63:0]  pp_q;
  logic [1:0]   psh_q;
  logic [2:0]   mph_q;
  logic         mbusy_q;
  mul_sel_e     msel_q;
  logic [31:0]  a_part, b_part;
  logic         mul_done;
  logic [63:0]  tv;

  // Divider.
  logic [63:0] dvd_q, quo_q, quo_n;
  logic [47:0] rem_q, rem_n;
  logic [48:0] r_try, r_sub;
  logic        r_ge;
  logic        dch_q;
  logic [5:0]  dcnt_q;
  logic        dbusy_q;
  logic        div_done;
  logic [47:0] slack;
  logic [63:0] dt_q [2];

  // Event selection and advance.
  logic        u_q;
  logic [63:0] dtu;
  logic [64:0] tsum;

  // Output registers.
  logic [31:0] ot_q, ob_q;
  logic [19:0] oc_q;
  logic        of_q;
  logic [1:0]  os_q;

  assign iprod    = PW'(time_q) * PW'(STEPS_PER_UNIT);
  assign iraw     = iprod[PW-1:16];
  assign idx_d    = (iraw >= IW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : iraw[AW-1:0];
  assign tidx_ext = 32'(tidx_q);
  assign tbl_we   = cmd_i.tbl_wr && (tidx_ext < 32'(TABLE_DEPTH));

  assign neg = (rate_q < death_q);
  assign mag = neg ? (death_q - rate_q) : (rate_q - death_q);

  always_comb begin
    dth_a = neg ? ($signed({3'b000, xd_q}) - $signed({3'b000, di_q}))
                : ($signed({3'b000, xd_q}) + $signed({3'b000, di_q}));
    brt_a = neg ? ($signed({3'b000, xb_q}) + $signed({3'b000, bi_q}))
                : ($signed({3'b000, xb_q}) - $signed({3'b000, bi_q}));
    if (brt_a[63]) begin
      p0_d  = 48'd0;
      dth_f = dth_a - brt_a;
    end else begin
      p0_d  = clamp48(brt_a);
      dth_f = dth_a;
    end
    p1_d = clamp48(dth_f);
  end

  assign x64 = 64'(count_q);
  assign dtu = dt_q[u_q];

  always_comb begin
    case (cmd_i.msel)
      MS_N2: begin
        opa = x64;
        opb = x64 - 64'd1;
      end
      MS_IP: begin
        opa = 64'(bcrowd_q);
        opb = 64'(mag);
      end
      MS_IQ: begin
        opa = 64'(dcrowd_q);
        opb = 64'(mag);
      end
      MS_XD: begin
        opa = x64;
        opb = 64'(death_q);
      end
      MS_DI: begin
        opa = n2_q;
        opb = 64'(iq_q);
      end
      MS_XB: begin
        opa = x64;
        opb = 64'(rate_q);
      end
      MS_BI: begin
        opa = n2_q;
        opb = 64'(ip_q);
      end
      MS_T0: begin
        opa = 64'(prop_q[0]);
        opb = dtu;
      end
      MS_T1: begin
        opa = 64'(prop_q[1]);
        opb = dtu;
      end
      default: begin
        opa = 64'd0;
        opb = 64'd0;
      end
    endcase
  end

  assign a_part = mph_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_part = mph_q[0] ? mb_q[63:32] : mb_q[31:0];

  always_comb begin
    case (psh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = {32'd0, pp_q, 32'd0};
    endcase
    acc_n = (mph_q == 3'd0) ? acc_q : (acc_q + pp_sh);
  end

  assign mul_done = mbusy_q && (mph_q == MUL_LAST);
  assign tv       = (|acc_n[127:64]) ? {64{1'b1}} : acc_n[63:0];

  assign slack = (nf_q[cmd_i.div_ch] > it_q[cmd_i.div_ch])
                 ? (nf_q[cmd_i.div_ch] - it_q[cmd_i.div_ch]) : 48'd0;
  assign r_try = {rem_q, dvd_q[63]};
  assign r_sub = r_try - {1'b0, prop_q[dch_q]};
  assign r_ge  = (r_try >= {1'b0, prop_q[dch_q]});
  assign rem_n = r_ge ? r_sub[47:0] : r_try[47:0];
  assign quo_n = {quo_q[62:0], r_ge};
  assign div_done = dbusy_q && (dcnt_q == 6'd0);

  assign tsum = {1'b0, dtu} + 65'(time_q);

  assign sts_o.end_hit  = (time_q >= end_q);
  assign sts_o.ok0      = (prop_q[0] != 48'd0);
  assign sts_o.ok1      = (prop_q[1] != 48'd0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tidx_ext[AW-1:0]] <= tval_q;
    end
    if (cmd_i.rd) begin
      rate_q <= tbl_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      death_q   <= 32'd0;
      bcrowd_q  <= 32'd0;
      dcrowd_q  <= 32'd0;
      end_q     <= 32'd0;
      time_q    <= 32'd0;
      count_q   <= '0;
      prop_q[0] <= 48'd0;
      prop_q[1] <= 48'd0;
      it_q[0]   <= 48'd0;
      it_q[1]   <= 48'd0;
      nf_q[0]   <= 48'd0;
      nf_q[1]   <= 48'd0;
      fired_q   <= 1'b0;
      status_q  <= ST_OK;
      mbusy_q   <= 1'b0;
      mph_q     <= 3'd0;
      dbusy_q   <= 1'b0;
      dcnt_q    <= 6'd0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DEATH_COEF:  death_q <= cfg_data_i;
          CFG_BIRTH_CROWD: bcrowd_q <= cfg_data_i;
          CFG_DEATH_CROWD: dcrowd_q <= cfg_data_i;
          CFG_END_TIME:    end_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.cap) begin
        fired_q  <= 1'b0;
        status_q <= ST_OK;
      end
      if (cmd_i.set_st) begin
        status_q <= cmd_i.st;
      end
      if (cmd_i.start) begin
        count_q <= (33'(cnt_in_q) > CMAX33) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(cnt_in_q);
        time_q  <= 32'd0;
        it_q[0] <= 48'd0;
        it_q[1] <= 48'd0;
        nf_q[0] <= 48'(smp_a_q);
        nf_q[1] <= 48'(smp_b_q);
      end
      if (cmd_i.adv) begin
        time_q     <= (|tsum[64:32]) ? 32'hFFFF_FFFF : tsum[31:0];
        nf_q[u_q]  <= add48(nf_q[u_q], 48'(smp_a_q));
        fired_q    <= u_q;
        if (!u_q) begin
          if (count_q != {COUNT_BITS{1'b1}}) begin
            count_q <= count_q + 1'b1;
          end
        end else if (count_q != '0) begin
          count_q <= count_q - 1'b1;
        end
      end
      if (cmd_i.rates) begin
        prop_q[0] <= p0_d;
        prop_q[1] <= p1_d;
      end
      if (cmd_i.mul_go) begin
        mbusy_q <= 1'b1;
        mph_q   <= 3'd0;
      end else if (mbusy_q) begin
        mph_q <= mph_q + 3'd1;
        if (mul_done) begin
          mbusy_q <= 1'b0;
          if (msel_q == MS_T0) begin
            it_q[0] <= add48(it_q[0], tv[63:16]);
          end else if (msel_q == MS_T1) begin
            it_q[1] <= add48(it_q[1], tv[63:16]);
          end
        end
      end
      if (cmd_i.div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 6'd63;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (div_done) begin
          dbusy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      tidx_q   <= table_index_i;
      tval_q   <= table_value_i;
      cnt_in_q <= start_count_i;
      smp_a_q  <= exp_sample_a_i;
      smp_b_q  <= exp_sample_b_i;
    end
    if (cmd_i.idx) begin
      idx_q <= idx_d;
    end
    if (cmd_i.sel) begin
      u_q <= (!sts_o.ok1 || (sts_o.ok0 && (dt_q[0] <= dt_q[1]))) ? 1'b0 : 1'b1;
    end
    if (cmd_i.mul_go) begin
      ma_q   <= opa;
      mb_q   <= opb;
      acc_q  <= 128'd0;
      msel_q <= cmd_i.msel;
    end else if (mbusy_q) begin
      acc_q <= acc_n;
      if (mph_q != MUL_LAST) begin
        pp_q  <= a_part * b_part;
        psh_q <= mph_q[1:0];
      end
      if (mul_done) begin
        case (msel_q)
          MS_N2:   n2_q <= acc_n[63:0];
          MS_IP:   ip_q <= acc_n[63:16];
          MS_IQ:   iq_q <= acc_n[63:16];
          MS_XD:   xd_q <= sat60(acc_n);
          MS_DI:   di_q <= sat60(acc_n);
          MS_XB:   xb_q <= sat60(acc_n);
          MS_BI:   bi_q <= sat60(acc_n);
          default: ;
        endcase
      end
    end
    if (cmd_i.div_go) begin
      dvd_q <= {slack, 16'd0};
      rem_q <= 48'd0;
      quo_q <= 64'd0;
      dch_q <= cmd_i.div_ch;
    end else if (dbusy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (div_done) begin
        dt_q[dch_q] <= quo_n;
      end
    end
    if (cmd_i.out_ld) begin
      ot_q <= time_q;
      oc_q <= 20'(count_q);
      ob_q <= rate_q;
      of_q <= fired_q;
      os_q <= status_q;
    end
  end

  assign time_now_o       = ot_q;
  assign count_now_o      = oc_q;
  assign birth_rate_now_o = ob_q;
  assign fired_channel_o  = of_q;
  assign status_o         = os_q;

endmodule
